[rtl/mcst_pkg.sv]
// shared types and constants of the soft timer table
// depends on nothing; used by every rtl module and the testbench
package mcst_pkg;

  localparam int NUM_SLOTS = 16;

  localparam int CMD_W    = 4;
  localparam int AMOUNT_W = 24;
  localparam int FRAME_W  = 48;
  localparam int ID_W     = 4;
  localparam int TAG_W    = 8;
  localparam int KIND_W   = 2;
  localparam int ANS_W    = 16;
  localparam int MPF_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ANS_W-1:0] RST_WAKE_CEILING  = 16'd100;
  localparam logic [MPF_W-1:0] RST_FRAME_RATE_MS = 8'd17;

  typedef enum logic [CMD_W-1:0] {
    CMD_AFTER_MS     = 4'd0,
    CMD_EVERY_MS     = 4'd1,
    CMD_AFTER_FRAMES = 4'd2,
    CMD_EVERY_FRAMES = 4'd3,
    CMD_STOP_ID      = 4'd4,
    CMD_STOP_TAG     = 4'd5,
    CMD_STOP_ALL     = 4'd6,
    CMD_QUERY        = 4'd7,
    CMD_COUNT        = 4'd8,
    CMD_TICK         = 4'd9,
    CMD_FRAME        = 4'd10,
    CMD_NEXT_WAKE    = 4'd11
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_END   = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAKE_CEILING  = 2'd0,
    REG_FRAME_RATE_MS = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [AMOUNT_W-1:0] amount;
    logic [FRAME_W-1:0]  frame_number;
    logic [ID_W-1:0]     timer_id;
    logic [TAG_W-1:0]    handler_tag;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   slot_id;
    logic [TAG_W-1:0]  fired_tag;
    logic              repeating;
    logic              active_flag;
    logic [ANS_W-1:0]  answer_value;
    logic              last;
  } rsp_t;

  // one slot entry of the timer memory; elapsed stays below a nonzero period while the slot is active
  typedef struct packed {
    logic                frame_based;
    logic                periodic;
    logic [TAG_W-1:0]    tag;
    logic [AMOUNT_W-1:0] period;
    logic [AMOUNT_W-1:0] elapsed;
    logic [FRAME_W-1:0]  target;
  } entry_t;

endpackage

[rtl/mcst_chan_if.sv]
// valid/ready channel carrying one word of a payload type
// payload types come from mcst_pkg
interface mcst_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mcst_rem.sv]
// restoring remainder unit, one quotient bit per cycle
// depends on mcst_pkg for the field widths
module mcst_rem (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mcst_pkg::AMOUNT_W:0]      dividend,
  input  logic [mcst_pkg::AMOUNT_W-1:0]    divisor,
  output logic                             done,
  output logic [mcst_pkg::AMOUNT_W-1:0]    rem
);

  localparam int NW = mcst_pkg::AMOUNT_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num;
  logic [NW-1:0] r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [NW-1:0] trial;
  logic [NW-1:0] dext;

  assign dext  = {1'b0, divisor};
  assign trial = {r[NW-2:0], num[NW-1]};
  assign rem   = r[NW-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        num <= dividend;
        r   <= '0;
      end else if (run) begin
        num <= {num[NW-2:0], 1'b0};
        r   <= (trial >= dext) ? (trial - dext) : trial;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/multi_channel_soft_timer_table_top.sv]
// soft timer table: slot entries in one synchronous memory, active bits in flops
// sequencing: stop id, stop all, query and unknown commands go straight to the finish state;
// other commands walk the slots through read and execute for register, stop tag and count,
// tick, frame and next wake add a write-back state for each slot they touch,
// plus a remainder wait for each periodic tick remainder; registration stops at the first free slot
// throughput: one command at a time, set by the single memory port and the walk loop
// reset: rst synchronous; clears active bits, control and registers; no memory clear
module multi_channel_soft_timer_table_top (
  input  logic                              clk,
  input  logic                              rst,
  mcst_chan_if.sink                         request,
  mcst_chan_if.source                       response,
  input  logic                              cfg_we,
  input  logic [mcst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcst_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW = (mcst_pkg::NUM_SLOTS > 1) ? $clog2(mcst_pkg::NUM_SLOTS) : 1;
  localparam int CW = $clog2(mcst_pkg::NUM_SLOTS + 1);
  localparam int TW = mcst_pkg::AMOUNT_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_EX   = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_WB   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration registers
  logic [mcst_pkg::ANS_W-1:0] wake_ceiling;
  logic [mcst_pkg::MPF_W-1:0] frame_rate_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_ceiling  <= mcst_pkg::RST_WAKE_CEILING;
      frame_rate_ms <= mcst_pkg::RST_FRAME_RATE_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        mcst_pkg::REG_WAKE_CEILING: wake_ceiling <= cfg_data;
        mcst_pkg::REG_FRAME_RATE_MS: frame_rate_ms <= cfg_data[mcst_pkg::MPF_W-1:0];
        default: ;
      endcase
    end
  end

  // slot memory and active bits
  mcst_pkg::entry_t mem [mcst_pkg::NUM_SLOTS];
  mcst_pkg::entry_t rd_q;
  mcst_pkg::entry_t wdata;
  logic             mem_we;
  logic [mcst_pkg::NUM_SLOTS-1:0] active;
  logic [SW-1:0]    slot;
  logic             slot_last;

  assign slot_last = (slot == SW'(mcst_pkg::NUM_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (mem_we) mem[slot] <= wdata;
    if (state == ST_RD) rd_q <= mem[slot];
  end

  // latched command word and walk registers
  mcst_pkg::req_t req_q;
  logic           reg_cmd;
  logic           id_ok;
  logic [SW-1:0]  id_slot;
  logic           query_q;
  logic           reg_full_q;
  logic [SW-1:0]  reg_slot_q;
  logic [CW-1:0]  cnt_q;
  logic [mcst_pkg::ANS_W-1:0] best_q;
  logic           wk_q;         // slot takes part in this walk step
  logic           fire_q;
  logic [TW-1:0]  sum_q;        // tick sum, or wake time with top bit as saturation
  logic [mcst_pkg::FRAME_W-1:0] target_q;

  assign reg_cmd = (req_q.command <= mcst_pkg::CMD_EVERY_FRAMES);
  assign id_ok   = (int'(request.data.timer_id) < mcst_pkg::NUM_SLOTS);
  assign id_slot = SW'(request.data.timer_id);

  // execute-stage arithmetic on the read entry
  logic [TW-1:0]                 tick_sum;
  logic                          tick_fire;
  logic                          frame_due;
  logic [mcst_pkg::FRAME_W-1:0]  frame_diff;
  logic [mcst_pkg::FRAME_W-1:0]  frame_next;
  logic [mcst_pkg::AMOUNT_W-1:0] wake_prod;
  logic                          ms_due;
  logic                          slot_on;

  assign slot_on    = active[slot];
  assign tick_sum   = {1'b0, rd_q.elapsed} + {1'b0, req_q.amount};
  assign tick_fire  = (tick_sum >= {1'b0, rd_q.period});
  assign frame_due  = (req_q.frame_number >= rd_q.target);
  assign frame_diff = rd_q.target - req_q.frame_number;
  assign frame_next = req_q.frame_number + mcst_pkg::FRAME_W'(rd_q.period);
  assign wake_prod  = frame_diff[15:0] * frame_rate_ms;
  assign ms_due     = (rd_q.elapsed >= rd_q.period);

  // remainder unit for periodic ms timers; it takes the sum as it starts
  logic                          div_start;
  logic                          div_done;
  logic [mcst_pkg::AMOUNT_W-1:0] div_rem;

  mcst_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tick_sum),
    .divisor  (rd_q.period),
    .done     (div_done),
    .rem      (div_rem)
  );

  // output register
  mcst_pkg::rsp_t out_q;
  logic           out_valid;
  logic           out_free;
  mcst_pkg::rsp_t fin_rsp;
  mcst_pkg::rsp_t fire_rsp;

  assign out_free       = !out_valid || response.ready;
  assign response.valid = out_valid;
  assign response.data  = out_q;
  assign request.ready  = (state == ST_IDLE);

  always_comb begin
    fire_rsp             = '0;
    fire_rsp.kind        = mcst_pkg::KIND_FIRED;
    fire_rsp.slot_id     = mcst_pkg::ID_W'(slot);
    fire_rsp.fired_tag   = rd_q.tag;
    fire_rsp.repeating   = rd_q.periodic;

    fin_rsp      = '0;
    fin_rsp.last = 1'b1;
    fin_rsp.kind = mcst_pkg::KIND_ACK;
    case (req_q.command) inside
      [mcst_pkg::CMD_AFTER_MS:mcst_pkg::CMD_EVERY_FRAMES]: begin
        if (reg_full_q) fin_rsp.kind = mcst_pkg::KIND_FULL;
        else fin_rsp.slot_id = mcst_pkg::ID_W'(reg_slot_q);
      end
      mcst_pkg::CMD_STOP_ID: fin_rsp.slot_id = req_q.timer_id;
      mcst_pkg::CMD_QUERY: begin
        fin_rsp.slot_id     = req_q.timer_id;
        fin_rsp.active_flag = query_q;
      end
      mcst_pkg::CMD_COUNT: fin_rsp.answer_value = mcst_pkg::ANS_W'(cnt_q);
      mcst_pkg::CMD_NEXT_WAKE: fin_rsp.answer_value = best_q;
      mcst_pkg::CMD_TICK, mcst_pkg::CMD_FRAME: fin_rsp.kind = mcst_pkg::KIND_END;
      default: ;
    endcase
  end

  // memory write: new entry on registration, updated elapsed count or frame target on write-back
  always_comb begin
    mem_we = 1'b0;
    wdata  = rd_q;
    if (state == ST_EX && reg_cmd && !slot_on) begin
      mem_we            = 1'b1;
      wdata.frame_based = (req_q.command >= mcst_pkg::CMD_AFTER_FRAMES);
      wdata.periodic    = req_q.command[0];
      wdata.tag         = req_q.handler_tag;
      wdata.period      = req_q.amount;
      wdata.elapsed     = '0;
      wdata.target      = wdata.frame_based
                          ? (req_q.frame_number + mcst_pkg::FRAME_W'(req_q.amount)) : '0;
    end else if (state == ST_WB && wk_q && (!fire_q || out_free)) begin
      if (req_q.command == mcst_pkg::CMD_TICK) begin
        mem_we        = 1'b1;
        wdata.elapsed = !fire_q ? sum_q[mcst_pkg::AMOUNT_W-1:0]
                      : (rd_q.period == '0) ? '0 : div_rem;
      end else if (req_q.command == mcst_pkg::CMD_FRAME && fire_q) begin
        mem_we       = 1'b1;
        wdata.target = target_q;
      end
    end
  end

  assign div_start = (state == ST_EX) && (req_q.command == mcst_pkg::CMD_TICK) && slot_on
                     && !rd_q.frame_based && tick_fire && rd_q.periodic
                     && (rd_q.period != '0);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      slot      <= '0;
    end else begin
      if (response.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (request.valid) begin
            req_q      <= request.data;
            slot       <= '0;
            cnt_q      <= '0;
            best_q     <= wake_ceiling;
            reg_full_q <= 1'b0;
            query_q    <= id_ok && active[id_slot];
            case (request.data.command) inside
              [mcst_pkg::CMD_AFTER_MS:mcst_pkg::CMD_EVERY_FRAMES],
              mcst_pkg::CMD_STOP_TAG, mcst_pkg::CMD_COUNT, mcst_pkg::CMD_TICK,
              mcst_pkg::CMD_FRAME, mcst_pkg::CMD_NEXT_WAKE: state <= ST_RD;
              mcst_pkg::CMD_STOP_ID: begin
                if (id_ok) active[id_slot] <= 1'b0;
                state <= ST_FIN;
              end
              mcst_pkg::CMD_STOP_ALL: begin
                active <= '0;
                state  <= ST_FIN;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_RD: state <= ST_EX;
        ST_EX: begin
          wk_q     <= 1'b0;
          fire_q   <= 1'b0;
          sum_q    <= tick_sum;
          target_q <= frame_next;
          state    <= slot_last ? ST_FIN : ST_RD;
          if (!slot_last) slot <= slot + 1'b1;
          case (req_q.command) inside
            [mcst_pkg::CMD_AFTER_MS:mcst_pkg::CMD_EVERY_FRAMES]: begin
              if (!slot_on) begin
                active[slot] <= 1'b1;
                reg_slot_q   <= slot;
                state        <= ST_FIN;
                slot         <= slot;
              end else if (slot_last) begin
                reg_full_q <= 1'b1;
              end
            end
            mcst_pkg::CMD_STOP_TAG: begin
              if (slot_on && rd_q.tag == req_q.handler_tag) active[slot] <= 1'b0;
            end
            mcst_pkg::CMD_COUNT: begin
              if (slot_on) cnt_q <= cnt_q + 1'b1;
            end
            mcst_pkg::CMD_TICK: begin
              if (slot_on && !rd_q.frame_based) begin
                wk_q   <= 1'b1;
                fire_q <= tick_fire;
                slot   <= slot;
                state  <= div_start ? ST_DIV : ST_WB;
              end
            end
            mcst_pkg::CMD_FRAME: begin
              if (slot_on && rd_q.frame_based) begin
                wk_q   <= 1'b1;
                fire_q <= frame_due;
                slot   <= slot;
                state  <= ST_WB;
              end
            end
            mcst_pkg::CMD_NEXT_WAKE: begin
              if (slot_on) begin
                wk_q  <= 1'b1;
                slot  <= slot;
                state <= ST_WB;
                // wake time: top bit set means beyond any 16-bit ceiling
                if (rd_q.frame_based) begin
                  if (frame_due) sum_q <= '0;
                  else if (frame_diff[mcst_pkg::FRAME_W-1:16] != '0 && frame_rate_ms != '0)
                    sum_q <= '1;
                  else sum_q <= {1'b0, wake_prod};
                end else begin
                  sum_q <= ms_due ? '0 : {1'b0, rd_q.period - rd_q.elapsed};
                end
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          if (div_done) state <= ST_WB;
        end
        ST_WB: begin
          if (!fire_q || out_free) begin
            if (req_q.command == mcst_pkg::CMD_NEXT_WAKE) begin
              if (sum_q < TW'(best_q)) best_q <= sum_q[mcst_pkg::ANS_W-1:0];
            end else if (fire_q) begin
              out_q     <= fire_rsp;
              out_valid <= 1'b1;
              if (!rd_q.periodic) active[slot] <= 1'b0;
            end
            state <= slot_last ? ST_FIN : ST_RD;
            if (!slot_last) slot <= slot + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_q     <= fin_rsp;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // the remainder unit only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("remainder done outside of its wait state");

  // registration never overwrites an active slot
  a_reg_free_slot: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_EX) |-> !active[slot])
    else $error("registration wrote an active slot");

  // an accepted command holds off the next one in the cycle after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("second command accepted while busy");

  // a word loaded into a busy output register would be lost
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !response.ready) |=> $stable(out_q))
    else $error("output word overwritten before taken");

endmodule

[test/multi_channel_soft_timer_table_top_test.sv]
// self-checking testbench for the soft timer table: drives commands, predicts every
// response word with its own slot model and checks them in order
// depends on mcst_pkg, mcst_chan_if and multi_channel_soft_timer_table_top
module multi_channel_soft_timer_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mcst_pkg::*;

  localparam int SLOTS = NUM_SLOTS;
  localparam int CYCLE_LIMIT = 4000000;

  // slot model plus the queue of response words still owed by the block
  class timer_table_scoreboard;
    bit        slot_on[SLOTS];
    bit        by_frame[SLOTS];
    bit        repeats[SLOTS];
    bit [7:0]  tag_of[SLOTS];
    bit [23:0] period_of[SLOTS];
    bit [31:0] elapsed_of[SLOTS];
    bit [47:0] due_frame[SLOTS];
    bit [15:0] ceiling_ms = RST_WAKE_CEILING;
    bit [7:0]  frame_ms = RST_FRAME_RATE_MS;
    rsp_t      owed_words[$];
    int        mismatches;

    function void write_reg(reg_idx_t idx, bit [15:0] value);
      if (idx == REG_WAKE_CEILING) ceiling_ms = value;
      else if (idx == REG_FRAME_RATE_MS) frame_ms = value[7:0];
    endfunction

    function void owe(kind_t k, bit [3:0] slot, bit [7:0] tag, bit rep, bit act,
                      bit [15:0] ans, bit fin);
      rsp_t w;
      w.kind = k; w.slot_id = slot; w.fired_tag = tag; w.repeating = rep;
      w.active_flag = act; w.answer_value = ans; w.last = fin;
      owed_words.push_back(w);
    endfunction

    function void note_command(req_t r);
      int s;
      int n;
      longint unsigned best;
      longint unsigned t;
      case (r.command)
        CMD_AFTER_MS, CMD_EVERY_MS, CMD_AFTER_FRAMES, CMD_EVERY_FRAMES: begin
          for (s = 0; s < SLOTS; s++) if (!slot_on[s]) break;
          if (s >= SLOTS) begin
            owe(KIND_FULL, 0, 0, 0, 0, 0, 1);
          end else begin
            slot_on[s] = 1;
            repeats[s] = r.command[0];
            by_frame[s] = r.command >= CMD_AFTER_FRAMES;
            tag_of[s] = r.handler_tag;
            period_of[s] = r.amount;
            elapsed_of[s] = 0;
            due_frame[s] = by_frame[s] ? r.frame_number + 48'(r.amount) : 48'd0;
            owe(KIND_ACK, s[3:0], 0, 0, 0, 0, 1);
          end
        end
        CMD_STOP_ID: begin
          slot_on[r.timer_id] = 0;
          owe(KIND_ACK, r.timer_id, 0, 0, 0, 0, 1);
        end
        CMD_STOP_TAG: begin
          for (s = 0; s < SLOTS; s++)
            if (slot_on[s] && tag_of[s] == r.handler_tag) slot_on[s] = 0;
          owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
        end
        CMD_STOP_ALL: begin
          for (s = 0; s < SLOTS; s++) slot_on[s] = 0;
          owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
        end
        CMD_QUERY: owe(KIND_ACK, r.timer_id, 0, 0, slot_on[r.timer_id], 0, 1);
        CMD_COUNT: begin
          n = 0;
          for (s = 0; s < SLOTS; s++) n += slot_on[s];
          owe(KIND_ACK, 0, 0, 0, 0, n[15:0], 1);
        end
        CMD_TICK: begin
          for (s = 0; s < SLOTS; s++) begin
            if (!slot_on[s] || by_frame[s]) continue;
            elapsed_of[s] += r.amount;
            if (elapsed_of[s] >= period_of[s]) begin
              owe(KIND_FIRED, s[3:0], tag_of[s], repeats[s], 0, 0, 0);
              if (!repeats[s]) slot_on[s] = 0;
              else if (period_of[s] == 0) elapsed_of[s] = 0;
              else elapsed_of[s] = elapsed_of[s] % period_of[s];
            end
          end
          owe(KIND_END, 0, 0, 0, 0, 0, 1);
        end
        CMD_FRAME: begin
          for (s = 0; s < SLOTS; s++) begin
            if (!slot_on[s] || !by_frame[s]) continue;
            if (r.frame_number >= due_frame[s]) begin
              owe(KIND_FIRED, s[3:0], tag_of[s], repeats[s], 0, 0, 0);
              if (!repeats[s]) slot_on[s] = 0;
              else due_frame[s] = r.frame_number + 48'(period_of[s]);
            end
          end
          owe(KIND_END, 0, 0, 0, 0, 0, 1);
        end
        CMD_NEXT_WAKE: begin
          best = ceiling_ms;
          for (s = 0; s < SLOTS; s++) begin
            if (!slot_on[s]) continue;
            if (by_frame[s])
              t = (r.frame_number >= due_frame[s]) ? 0 :
                  64'(due_frame[s] - r.frame_number) * 64'(frame_ms);
            else
              t = (elapsed_of[s] >= period_of[s]) ? 0 :
                  64'(period_of[s]) - 64'(elapsed_of[s]);
            if (t < best) best = t;
          end
          owe(KIND_ACK, 0, 0, 0, 0, best[15:0], 1);
        end
        default: owe(KIND_ACK, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response word %p", got);
        return;
      end
      want = owed_words.pop_front();
      if (got.kind !== want.kind || got.slot_id !== want.slot_id ||
          got.fired_tag !== want.fired_tag || got.repeating !== want.repeating ||
          got.active_flag !== want.active_flag ||
          got.answer_value !== want.answer_value || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mcst_chan_if #(.payload_t(req_t)) request_ch ();
  mcst_chan_if #(.payload_t(rsp_t)) response_ch ();

  multi_channel_soft_timer_table_top u_top (
    .clk(clk), .rst(rst),
    .request(request_ch), .response(response_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  timer_table_scoreboard board = new();

  // idle percentages per side, and a counted receiver hold-off for back pressure
  int sender_idle_pct = 34;
  int receiver_idle_pct = 61;
  int hold_off_left = 0;
  int cycle_count = 0;
  bit [47:0] frame_now = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    request_ch.valid = 0;
    request_ch.data = '0;
    response_ch.ready = 0;
  end

  // receiver: ready changes at the falling edge only
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      response_ch.ready <= 0;
    end else begin
      response_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // response monitor samples at the rising edge
  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready) board.check_word(response_ch.data);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer one word, idling first at random; the word is noted when accepted
  task automatic send_word(req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      request_ch.valid <= 0;
    end
    @(negedge clk);
    request_ch.valid <= 1;
    request_ch.data <= r;
    forever begin
      @(posedge clk);
      if (request_ch.ready) break;
    end
    board.note_command(r);
  endtask

  task automatic send(logic [3:0] cmd, logic [23:0] amt, logic [47:0] frm,
                      logic [3:0] id, logic [7:0] tag);
    req_t r;
    r.command = cmd; r.amount = amt; r.frame_number = frm;
    r.timer_id = id; r.handler_tag = tag;
    send_word(r);
  endtask

  // wait until every owed word has arrived, with the valid line low
  task automatic wait_drained();
    @(negedge clk);
    request_ch.valid <= 0;
    while (board.owed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, value);
  endtask

  function automatic logic [23:0] pick_amount(int hi);
    return ($urandom_range(99) < 5) ? 24'($urandom) : 24'($urandom_range(hi));
  endfunction

  function automatic logic [7:0] pick_tag();
    return ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(7));
  endfunction

  // mostly register and advance time so timers fire; rarer stops and queries
  task automatic send_random();
    int p;
    logic [47:0] frm;
    p = $urandom_range(99);
    frm = ($urandom_range(99) < 3) ? {16'($urandom), 32'($urandom)} : frame_now;
    if (p < 35) begin
      send(4'($urandom_range(3)), pick_amount(40), frm, 4'($urandom), pick_tag());
    end else if (p < 55) begin
      send(CMD_TICK, pick_amount(20), 48'($urandom), 4'($urandom), 8'($urandom));
    end else if (p < 67) begin
      frame_now = frame_now + $urandom_range(5);
      if ($urandom_range(99) >= 3) frm = frame_now;
      send(CMD_FRAME, 24'($urandom), frm, 4'($urandom), 8'($urandom));
    end else if (p < 75) begin
      send(CMD_NEXT_WAKE, 24'($urandom), frm, 4'($urandom), 8'($urandom));
    end else if (p < 81) begin
      send(CMD_QUERY, 24'($urandom), 48'($urandom), 4'($urandom), 8'($urandom));
    end else if (p < 85) begin
      send(CMD_COUNT, 24'($urandom), 48'($urandom), 4'($urandom), 8'($urandom));
    end else if (p < 91) begin
      send(CMD_STOP_ID, 24'($urandom), 48'($urandom), 4'($urandom), 8'($urandom));
    end else if (p < 95) begin
      send(CMD_STOP_TAG, 24'($urandom), 48'($urandom), 4'($urandom), pick_tag());
    end else if (p < 97) begin
      send(CMD_STOP_ALL, 24'($urandom), 48'($urandom), 4'($urandom), 8'($urandom));
    end else begin
      // codes past the last command are only acknowledged
      send(4'($urandom_range(15, 12)), 24'($urandom), 48'($urandom), 4'($urandom),
           8'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, every command, zero periods, wrapping target, full table
    send(CMD_AFTER_MS, 24'd0, 48'd0, 4'd0, 8'hFF);
    send(CMD_EVERY_MS, 24'd0, 48'd0, 4'd0, 8'h00);
    send(CMD_EVERY_MS, 24'd5, 48'd0, 4'd0, 8'h01);
    send(CMD_AFTER_FRAMES, 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 4'd0, 8'h02);
    send(CMD_EVERY_FRAMES, 24'd3, 48'd10, 4'd0, 8'h02);
    send(CMD_QUERY, 24'd0, 48'd0, 4'd3, 8'd0);
    send(CMD_QUERY, 24'd0, 48'd0, 4'd15, 8'd0);
    send(CMD_COUNT, 24'd0, 48'd0, 4'd0, 8'd0);
    send(CMD_NEXT_WAKE, 24'd0, 48'd10, 4'd0, 8'd0);
    send(CMD_TICK, 24'd7, 48'd0, 4'd0, 8'd0);
    send(CMD_FRAME, 24'd0, 48'd13, 4'd0, 8'd0);
    send(CMD_TICK, 24'hFFFFFF, 48'd0, 4'd0, 8'd0);
    send(CMD_NEXT_WAKE, 24'd0, 48'd0, 4'd0, 8'd0);
    send(CMD_STOP_TAG, 24'd0, 48'd0, 4'd0, 8'h02);
    send(CMD_STOP_ID, 24'd0, 48'd0, 4'd2, 8'd0);
    send(CMD_STOP_ID, 24'd0, 48'd0, 4'd15, 8'd0);
    for (int c = 12; c < 16; c++) send(4'(c), 24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 4'hF, 8'hFF);
    for (int i = 0; i < 17; i++) send(CMD_AFTER_MS, 24'd1000, 48'd0, 4'd0, 8'(i));
    send(CMD_STOP_ALL, 24'd0, 48'd0, 4'd0, 8'd0);
    send(CMD_COUNT, 24'd0, 48'd0, 4'd0, 8'd0);
    wait_drained();

    // phase one: lowest ceiling, slowest frames; sender idles less than receiver
    write_reg(REG_WAKE_CEILING, 16'd0);
    write_reg(REG_FRAME_RATE_MS, 16'd255);
    sender_idle_pct = 34;
    receiver_idle_pct = 61;
    repeat (160) send_random();
    wait_drained();

    // phase two: highest ceiling, one ms per frame; idling swapped
    write_reg(REG_WAKE_CEILING, 16'hFFFF);
    write_reg(REG_FRAME_RATE_MS, 16'd1);
    sender_idle_pct = 61;
    receiver_idle_pct = 34;
    repeat (160) send_random();
    wait_drained();

    // phase three: zero ms per frame, no idling, a long receiver hold-off
    write_reg(REG_WAKE_CEILING, 16'd1234);
    write_reg(REG_FRAME_RATE_MS, 16'd0);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (40) send_random();
    hold_off_left = 3000;
    repeat (60) send_random();
    // sender waits for every owed word before going on
    wait_drained();
    repeat (80) send_random();

    wait_drained();
    repeat (600) @(posedge clk);
    if (board.mismatches == 0 && board.owed_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mcst_pkg.sv
rtl/mcst_chan_if.sv
rtl/mcst_rem.sv
rtl/multi_channel_soft_timer_table_top.sv
test/multi_channel_soft_timer_table_top_test.sv
